// ----- rtl/core/sieu_pkg.sv -----
`timescale 1ns / 1ps
// Package for the small ISA execute unit: operation codes, field widths and
// data memory geometry. No dependencies.
package sieu_pkg;

    localparam int OP_W      = 4;
    localparam int REGF_W    = 3;
    localparam int DATA_W    = 32;
    localparam int PC_W      = 16;
    localparam int IMM_W     = 16;
    localparam int PLA_W     = 10;

    localparam int MEM_DEPTH = 1024;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam int LINK_REG  = 1;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_ADD     = 4'd0;
    localparam t_op OP_SUB     = 4'd1;
    localparam t_op OP_ADDI    = 4'd2;
    localparam t_op OP_NAND    = 4'd3;
    localparam t_op OP_MUL     = 4'd4;
    localparam t_op OP_LOAD    = 4'd5;
    localparam t_op OP_STORE   = 4'd6;
    localparam t_op OP_JMP     = 4'd7;
    localparam t_op OP_BEQ     = 4'd8;
    localparam t_op OP_JAL     = 4'd9;
    localparam t_op OP_RET     = 4'd10;
    localparam t_op OP_PRELOAD = 4'd11;

endpackage

// ----- rtl/core/small_isa_execute_unit_top.sv -----
`timescale 1ns / 1ps
// Small ISA execute unit: register file and data memory in sieu_ram, pc in flops.
// Pipeline: register read at acceptance, execute stage with data memory access,
// write-back stage, then the output register.
// Throughput: one word per cycle; a low i_out_ready or the clearing pass stalls it.
// Reset: synchronous, active low; pc goes to 0, then a clearing pass over MEM_DEPTH
// (1024) addresses zeroes data memory and register file while o_in_ready stays low.
module small_isa_execute_unit_top #(
    parameter int NUM_REGS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sieu_pkg::PC_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [sieu_pkg::OP_W-1:0]   i_operation,
    input  logic [sieu_pkg::REGF_W-1:0] i_dest_reg,
    input  logic [sieu_pkg::REGF_W-1:0] i_src_reg_a,
    input  logic [sieu_pkg::REGF_W-1:0] i_src_reg_b,
    input  logic signed [sieu_pkg::IMM_W-1:0]  i_immediate,
    input  logic [sieu_pkg::PLA_W-1:0]  i_preload_address,
    input  logic signed [sieu_pkg::DATA_W-1:0] i_preload_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [sieu_pkg::PC_W-1:0]   o_next_pc,
    output logic                        o_reg_written,
    output logic [sieu_pkg::REGF_W-1:0] o_written_reg,
    output logic signed [sieu_pkg::DATA_W-1:0] o_written_value,
    output logic                        o_mem_written,
    output logic                        o_branch_taken
);

    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DW = sieu_pkg::DATA_W;
    localparam int PW = sieu_pkg::PC_W;
    localparam int AW = sieu_pkg::MEM_AW;
    localparam logic [RW-1:0] LINK_IDX = RW'(sieu_pkg::LINK_REG % NUM_REGS);

    function automatic logic [RW-1:0] reg_idx(input logic [sieu_pkg::REGF_W-1:0] f);
        logic [5:0] x;
        x = 6'(f);
        for (int i = 0; i < 8; i++) begin
            if (x >= 6'(NUM_REGS)) begin
                x = x - 6'(NUM_REGS);
            end
        end
        return RW'(x);
    endfunction

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // pc
    logic [PW-1:0] r_pc;

    // execute stage
    logic                          r_e_valid;
    sieu_pkg::t_op                 r_e_op;
    logic [RW-1:0]                 r_e_rd;
    logic [RW-1:0]                 r_e_ra;
    logic [RW-1:0]                 r_e_rb;
    logic [sieu_pkg::IMM_W-1:0]    r_e_imm;
    logic [sieu_pkg::PLA_W-1:0]    r_e_pl_addr;
    logic [DW-1:0]                 r_e_pl_val;

    // write-back stage
    logic          r_w_valid;
    logic          r_w_wr;
    logic          r_w_load;
    logic [RW-1:0] r_w_reg;
    logic [DW-1:0] r_w_value;
    logic [PW-1:0] r_w_npc;
    logic          r_w_mw;
    logic          r_w_bt;

    // output register
    logic                        r_o_valid;
    logic [PW-1:0]               r_o_next_pc;
    logic                        r_o_reg_written;
    logic [sieu_pkg::REGF_W-1:0] r_o_written_reg;
    logic [DW-1:0]               r_o_written_value;
    logic                        r_o_mem_written;
    logic                        r_o_branch_taken;

    logic          w_move, w_free, e_move, e_free, in_acc;
    logic [RW-1:0] in_ra, in_rb;
    logic [DW-1:0] rf_a, rf_b, mem_rdata;
    logic [DW-1:0] w_value, op_a, op_b, imm32, mem_sum;
    logic [PW-1:0] seq_pc, tgt_pc;
    logic          rf_we;
    logic [RW-1:0] rf_waddr;
    logic [DW-1:0] rf_wdata;
    logic          dm_we, dm_re;
    logic [AW-1:0] dm_waddr, dm_raddr;
    logic [DW-1:0] dm_wdata;

    logic          n_wr, n_load, n_mw, n_bt;
    logic [RW-1:0] n_reg;
    logic [DW-1:0] n_value;
    logic [PW-1:0] n_npc;

    assign w_move     = r_w_valid & (~r_o_valid | i_out_ready);
    assign w_free     = ~r_w_valid | w_move;
    assign e_move     = r_e_valid & w_free;
    assign e_free     = ~r_e_valid | e_move;
    assign o_in_ready = ~r_clr_busy & e_free;
    assign in_acc     = i_in_valid & o_in_ready;

    assign in_ra = reg_idx(i_src_reg_a);
    assign in_rb = (i_operation == sieu_pkg::OP_RET) ? LINK_IDX : reg_idx(i_src_reg_b);

    assign w_value = r_w_load ? mem_rdata : r_w_value;

    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = r_w_reg;
        rf_wdata = w_value;
        if (r_clr_busy) begin
            rf_we    = (r_clr_addr < AW'(NUM_REGS));
            rf_waddr = RW'(r_clr_addr);
            rf_wdata = '0;
        end else if (w_move && r_w_wr) begin
            rf_we = 1'b1;
        end
    end

    sieu_ram #(.WIDTH(DW), .DEPTH(NUM_REGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (in_acc),
        .i_raddr (in_ra),
        .o_rdata (rf_a)
    );

    sieu_ram #(.WIDTH(DW), .DEPTH(NUM_REGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (in_acc),
        .i_raddr (in_rb),
        .o_rdata (rf_b)
    );

    // forward the word in write-back over the stale register read
    assign op_a = (r_w_valid && r_w_wr && (r_w_reg == r_e_ra)) ? w_value : rf_a;
    assign op_b = (r_w_valid && r_w_wr && (r_w_reg == r_e_rb)) ? w_value : rf_b;

    assign imm32   = {{(DW-sieu_pkg::IMM_W){r_e_imm[sieu_pkg::IMM_W-1]}}, r_e_imm};
    assign mem_sum = op_b + imm32;
    assign seq_pc  = r_pc + 16'd1;
    assign tgt_pc  = seq_pc + r_e_imm;

    always_comb begin
        n_wr    = 1'b0;
        n_load  = 1'b0;
        n_mw    = 1'b0;
        n_bt    = 1'b0;
        n_reg   = r_e_rd;
        n_value = '0;
        n_npc   = seq_pc;
        unique case (r_e_op)
            sieu_pkg::OP_ADD: begin
                n_wr    = 1'b1;
                n_value = op_b + op_a;
            end
            sieu_pkg::OP_SUB: begin
                n_wr    = 1'b1;
                n_value = op_b - op_a;
            end
            sieu_pkg::OP_ADDI: begin
                n_wr    = 1'b1;
                n_value = op_a + imm32;
            end
            sieu_pkg::OP_NAND: begin
                n_wr    = 1'b1;
                n_value = ((op_a != '0) && (op_b != '0)) ? '0 : DW'(1);
            end
            sieu_pkg::OP_MUL: begin
                n_wr    = 1'b1;
                n_value = op_b * op_a;
            end
            sieu_pkg::OP_LOAD: begin
                n_wr   = 1'b1;
                n_load = 1'b1;
            end
            sieu_pkg::OP_STORE: begin
                n_mw = 1'b1;
            end
            sieu_pkg::OP_JMP: begin
                n_npc = tgt_pc;
                n_bt  = 1'b1;
            end
            sieu_pkg::OP_BEQ: begin
                if (op_a == op_b) begin
                    n_npc = tgt_pc;
                    n_bt  = 1'b1;
                end
            end
            sieu_pkg::OP_JAL: begin
                n_wr    = 1'b1;
                n_reg   = LINK_IDX;
                n_value = DW'(seq_pc);
                n_npc   = tgt_pc;
                n_bt    = 1'b1;
            end
            sieu_pkg::OP_RET: begin
                n_npc = op_b[PW-1:0];
                n_bt  = 1'b1;
            end
            sieu_pkg::OP_PRELOAD: begin
                n_mw  = 1'b1;
                n_npc = r_pc;
            end
            default: begin
                n_npc = r_pc;
            end
        endcase
        if (!n_wr) begin
            n_reg = '0;
        end
    end

    always_comb begin
        dm_we    = 1'b0;
        dm_waddr = mem_sum[AW-1:0];
        dm_wdata = op_a;
        if (r_clr_busy) begin
            dm_we    = 1'b1;
            dm_waddr = r_clr_addr;
            dm_wdata = '0;
        end else if (e_move && (r_e_op == sieu_pkg::OP_STORE)) begin
            dm_we = 1'b1;
        end else if (e_move && (r_e_op == sieu_pkg::OP_PRELOAD)) begin
            dm_we    = 1'b1;
            dm_waddr = AW'(r_e_pl_addr);
            dm_wdata = r_e_pl_val;
        end
    end

    assign dm_re    = e_move & (r_e_op == sieu_pkg::OP_LOAD);
    assign dm_raddr = mem_sum[AW-1:0];

    sieu_ram #(.WIDTH(DW), .DEPTH(sieu_pkg::MEM_DEPTH)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (dm_re),
        .i_raddr (dm_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_pc       <= '0;
            r_e_valid  <= 1'b0;
            r_w_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(sieu_pkg::MEM_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end else if (e_move) begin
                r_pc <= n_npc;
            end
            if (e_free) begin
                r_e_valid <= in_acc;
            end
            if (w_free) begin
                r_w_valid <= e_move;
            end
            if (w_move) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_e_op      <= i_operation;
            r_e_rd      <= reg_idx(i_dest_reg);
            r_e_ra      <= in_ra;
            r_e_rb      <= in_rb;
            r_e_imm     <= i_immediate;
            r_e_pl_addr <= i_preload_address;
            r_e_pl_val  <= i_preload_value;
        end
        if (e_move) begin
            r_w_wr    <= n_wr;
            r_w_load  <= n_load;
            r_w_reg   <= n_reg;
            r_w_value <= n_value;
            r_w_npc   <= n_npc;
            r_w_mw    <= n_mw;
            r_w_bt    <= n_bt;
        end
        if (w_move) begin
            r_o_next_pc       <= r_w_npc;
            r_o_reg_written   <= r_w_wr;
            r_o_written_reg   <= sieu_pkg::REGF_W'(r_w_reg);
            r_o_written_value <= w_value;
            r_o_mem_written   <= r_w_mw;
            r_o_branch_taken  <= r_w_bt;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_next_pc       = r_o_next_pc;
    assign o_reg_written   = r_o_reg_written;
    assign o_written_reg   = r_o_written_reg;
    assign o_written_value = r_o_written_value;
    assign o_mem_written   = r_o_mem_written;
    assign o_branch_taken  = r_o_branch_taken;

endmodule

// ----- rtl/core/sieu_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// A read of the address being written returns the new data. No dependencies.
module sieu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
